/* rtl/core/acc_pkg.sv */
// shared types and constants for the alarm clock controller
// no dependencies; imported by acc_core and alarm_clock_controller
package acc_pkg;

  // item kind carried in tuser
  typedef enum logic [1:0] {
    KIND_POLL   = 2'd0,
    KIND_STOP   = 2'd1,
    KIND_SNOOZE = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  // configuration register indexes
  localparam logic [2:0] REG_ALARM_HOUR    = 3'd0;
  localparam logic [2:0] REG_ALARM_MINUTE  = 3'd1;
  localparam logic [2:0] REG_ALARM_DUR     = 3'd2;
  localparam logic [2:0] REG_SNOOZE_DUR    = 3'd3;
  localparam logic [2:0] REG_TONE_PERIOD   = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 24;

  // value of the last-second register after reset, never a real second
  localparam logic [5:0] LAST_SECOND_RESET = 6'd60;

  typedef struct packed {
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic [14:0] alarm_duration_s;
    logic [14:0] snooze_duration_s;
    logic [15:0] tone_period_ms;
  } acc_cfg_t;

  typedef struct packed {
    logic [14:0] snooze_seconds_left;
    logic        snooze_event;
    logic        alarm_event;
    logic        time_event;
    logic        armed;
    logic        snoozing;
    logic        alarming;
    logic        tone_select;
    logic        sound_on;
  } acc_result_t;

endpackage

/* rtl/core/acc_core.sv */
// alarm state registers and the single-pass next-state / result logic
// depends on acc_pkg
module acc_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  acc_pkg::kind_t     kind,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  input  logic               switch_off,
  input  acc_pkg::acc_cfg_t  cfg,
  output acc_pkg::acc_result_t result
);
  import acc_pkg::*;

  logic        armed_flag, alarming_flag, snoozing_flag, stop_pending, silence_pending;
  logic        piezo_active, tone_toggle;
  logic [15:0] alarm_seconds_left, tone_ms_left;
  logic [14:0] snooze_left;
  logic [5:0]  last_second;

  logic        armed_flag_next, alarming_flag_next, snoozing_flag_next;
  logic        stop_pending_next, silence_pending_next;
  logic        piezo_active_next, tone_toggle_next;
  logic [15:0] alarm_seconds_left_next, tone_ms_left_next;
  logic [14:0] snooze_left_next;
  logic [5:0]  last_second_next;
  logic        time_ev, alarm_ev, snooze_ev;
  logic [15:0] dur_sum;
  logic        trip_match;

  assign dur_sum    = {1'b0, cfg.alarm_duration_s} + {1'b0, cfg.snooze_duration_s};
  assign trip_match = (second == 6'd0) && (minute == cfg.alarm_minute) &&
                      (hour == cfg.alarm_hour);

  always_comb begin
    armed_flag_next         = armed_flag;
    alarming_flag_next      = alarming_flag;
    snoozing_flag_next      = snoozing_flag;
    stop_pending_next       = stop_pending;
    silence_pending_next    = silence_pending;
    piezo_active_next       = piezo_active;
    tone_toggle_next        = tone_toggle;
    alarm_seconds_left_next = alarm_seconds_left;
    tone_ms_left_next       = tone_ms_left;
    snooze_left_next        = snooze_left;
    last_second_next        = last_second;
    time_ev                 = 1'b0;
    alarm_ev                = 1'b0;
    snooze_ev               = 1'b0;

    case (kind)
      KIND_POLL: begin
        if (stop_pending_next) begin
          alarm_seconds_left_next = '0;
          stop_pending_next       = 1'b0;
        end
        // alarm switch
        if (switch_off) begin
          if (armed_flag_next) begin
            armed_flag_next         = 1'b0;
            snooze_left_next        = '0;
            alarm_seconds_left_next = '0;
            if (alarming_flag_next) begin
              alarming_flag_next = 1'b0;
              snoozing_flag_next = 1'b0;
              piezo_active_next  = 1'b0;
              tone_toggle_next   = 1'b0;
            end
          end
        end else if (!armed_flag_next) begin
          armed_flag_next         = 1'b1;
          snooze_left_next        = '0;
          alarm_seconds_left_next = '0;
          tone_toggle_next        = 1'b0;
        end
        // new second: count down
        if (second != last_second) begin
          if (alarming_flag_next) begin
            if (snooze_left_next == 15'd1) begin
              snooze_ev          = 1'b1;
              snoozing_flag_next = 1'b0;
              tone_toggle_next   = 1'b0;
            end
            if (snooze_left_next != '0)
              snooze_left_next = snooze_left_next - 15'd1;
            if (alarm_seconds_left_next != '0)
              alarm_seconds_left_next = alarm_seconds_left_next - 16'd1;
          end
          last_second_next = second;
          time_ev          = 1'b1;
        end
        // trip or end
        if (armed_flag_next) begin
          if (!alarming_flag_next && trip_match) begin
            alarming_flag_next      = 1'b1;
            alarm_ev                = 1'b1;
            alarm_seconds_left_next = {1'b0, cfg.alarm_duration_s};
          end else if (alarming_flag_next && alarm_seconds_left_next == '0) begin
            alarming_flag_next   = 1'b0;
            snoozing_flag_next   = 1'b0;
            alarm_ev             = 1'b1;
            snooze_left_next     = '0;
            silence_pending_next = 1'b1;
          end
        end
      end
      KIND_STOP: begin
        if (alarming_flag)
          stop_pending_next = 1'b1;
      end
      KIND_SNOOZE: begin
        if (alarming_flag) begin
          snooze_left_next        = cfg.snooze_duration_s;
          snooze_ev               = 1'b1;
          snoozing_flag_next      = 1'b1;
          alarm_seconds_left_next = dur_sum;
          piezo_active_next       = 1'b0;
        end
      end
      KIND_TICK: begin
        if (alarming_flag && snooze_left == '0) begin
          if (tone_ms_left == '0) begin
            tone_ms_left_next = cfg.tone_period_ms;
            if (!piezo_active) begin
              piezo_active_next = 1'b1;
              tone_toggle_next  = ~tone_toggle;
            end else begin
              piezo_active_next = 1'b0;
            end
          end
          tone_ms_left_next = tone_ms_left_next - 16'd1;
        end else if (silence_pending) begin
          piezo_active_next    = 1'b0;
          silence_pending_next = 1'b0;
          tone_toggle_next     = 1'b0;
        end
      end
      default: begin
      end
    endcase

    result.sound_on            = piezo_active_next;
    result.tone_select         = piezo_active_next & ~tone_toggle_next;
    result.alarming            = alarming_flag_next;
    result.snoozing            = snoozing_flag_next;
    result.armed               = armed_flag_next;
    result.time_event          = time_ev;
    result.alarm_event         = alarm_ev;
    result.snooze_event        = snooze_ev;
    result.snooze_seconds_left = snooze_left_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag         <= 1'b0;
      alarming_flag      <= 1'b0;
      snoozing_flag      <= 1'b0;
      stop_pending       <= 1'b0;
      silence_pending    <= 1'b0;
      piezo_active       <= 1'b0;
      tone_toggle        <= 1'b0;
      alarm_seconds_left <= '0;
      tone_ms_left       <= '0;
      snooze_left        <= '0;
      last_second        <= LAST_SECOND_RESET;
    end else if (step) begin
      armed_flag         <= armed_flag_next;
      alarming_flag      <= alarming_flag_next;
      snoozing_flag      <= snoozing_flag_next;
      stop_pending       <= stop_pending_next;
      silence_pending    <= silence_pending_next;
      piezo_active       <= piezo_active_next;
      tone_toggle        <= tone_toggle_next;
      alarm_seconds_left <= alarm_seconds_left_next;
      tone_ms_left       <= tone_ms_left_next;
      snooze_left        <= snooze_left_next;
      last_second        <= last_second_next;
    end
  end

  // snooze only exists inside an active alarm
  a_snooze_in_alarm: assert property (@(posedge clk) disable iff (rst)
    snoozing_flag |-> alarming_flag)
    else $error("snoozing without alarming");

  // an alarm can only be active while armed
  a_alarm_armed: assert property (@(posedge clk) disable iff (rst)
    alarming_flag |-> armed_flag)
    else $error("alarming while disarmed");

  // state moves only when an item is processed
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> ($stable(alarming_flag) && $stable(snooze_left) && $stable(tone_ms_left)))
    else $error("state changed without an item");

  // seconds are only observed on polls
  a_time_ev_poll: assert property (@(posedge clk) disable iff (rst)
    (step && result.time_event) |-> (kind == KIND_POLL))
    else $error("time event on a non-poll item");

endmodule

/* rtl/core/alarm_clock_controller.sv */
// alarm clock controller top level: stream ports, config registers,
// input and result registers around acc_core; depends on acc_pkg, acc_core
// path: a slave-side transfer goes through the input register, then the result register
// throughput: one item per cycle while m_tready holds; the input register refills in the
// cycle it drains, and the result register is reloaded in the same cycle it is taken
// reset: synchronous, active high; clears handshake valids, alarm state and config to defaults
// every item yields exactly one result item
module alarm_clock_controller (
  input  logic                              clk,
  input  logic                              rst,
  // slave side
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [acc_pkg::IN_DATA_W-1:0]     s_tdata,   // hour[4:0], minute[10:5],
                                                       // second[16:11], switch_off[17], zero fill
  input  logic [1:0]                        s_tuser,   // kind[1:0]
  // master side
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [acc_pkg::OUT_DATA_W-1:0]    m_tdata,   // sound_on[0], tone_select[1],
                                                       // alarming[2], snoozing[3], armed[4],
                                                       // time_event[5], alarm_event[6],
                                                       // snooze_event[7],
                                                       // snooze_seconds_left[22:8], zero fill
  // configuration write port
  input  logic                              cfg_we,
  input  logic [acc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [acc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import acc_pkg::*;

  // input register
  logic        in_valid;
  kind_t       in_kind;
  logic [4:0]  in_hour;
  logic [5:0]  in_minute;
  logic [5:0]  in_second;
  logic        in_switch_off;

  // result register
  acc_result_t out_result;

  acc_cfg_t    cfg;
  acc_result_t step_result;
  logic        step;

  // process the held item when the result register is free or being drained
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarm_hour        <= 5'd8;
      cfg.alarm_minute      <= 6'd0;
      cfg.alarm_duration_s  <= 15'd300;
      cfg.snooze_duration_s <= 15'd540;
      cfg.tone_period_ms    <= 16'd150;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALARM_HOUR:   cfg.alarm_hour        <= cfg_data[4:0];
        REG_ALARM_MINUTE: cfg.alarm_minute      <= cfg_data[5:0];
        REG_ALARM_DUR:    cfg.alarm_duration_s  <= cfg_data[14:0];
        REG_SNOOZE_DUR:   cfg.snooze_duration_s <= cfg_data[14:0];
        REG_TONE_PERIOD:  cfg.tone_period_ms    <= cfg_data;
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // input register: loads on every slave-side transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind       <= kind_t'(s_tuser);
      in_hour       <= s_tdata[4:0];
      in_minute     <= s_tdata[10:5];
      in_second     <= s_tdata[16:11];
      in_switch_off <= s_tdata[17];
    end
  end

  acc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .kind       (in_kind),
    .hour       (in_hour),
    .minute     (in_minute),
    .second     (in_second),
    .switch_off (in_switch_off),
    .cfg        (cfg),
    .result     (step_result)
  );

  // result register: holds until the master-side transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - $bits(acc_result_t)){1'b0}}, out_result};

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// testbench for alarm_clock_controller: streams time polls, button requests and ms ticks
// through the slave side and checks every result against an in-bench alarm state model
// depends on acc_pkg and the alarm_clock_controller rtl
module tb_top;
  import acc_pkg::*;

  // idle cycles with no transfer on either side before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  // rough number of items to push through before the stimulus stops
  localparam int ITEM_TARGET = 1650;
  // items kept back for the final stretch with no idling
  localparam int TAIL_ITEMS = 300;

  // one input item, unpacked into its fields
  typedef struct packed {
    kind_t      kind;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       switch_off;
  } alarm_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;    // hour[4:0], minute[10:5], second[16:11], switch_off[17]
  logic [1:0]             s_tuser = '0;    // kind[1:0]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;         // sound_on[0] .. snooze_seconds_left[22:8]
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  alarm_clock_controller uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // alarm state model: configuration copy and state, advanced once per accepted item
  // ---------------------------------------------------------------------------
  logic [4:0]  set_hour;
  logic [5:0]  set_minute;
  logic [14:0] set_alarm_len;
  logic [14:0] set_snooze_len;
  logic [15:0] set_tone_len;

  logic        armed_q, alarming_q, snoozing_q;
  logic        stop_req_q;      // stop seen, applied on the next poll
  logic        silence_req_q;   // alarm over, piezo goes quiet on the next tick
  logic        piezo_q;
  logic        next_tone_q;     // frequency of the next tone slot
  logic [15:0] alarm_left_q;
  logic [14:0] snooze_left_q;
  logic [15:0] slot_left_q;
  logic [5:0]  seen_second_q;

  // expected results in transfer order
  acc_result_t expected_results[$];

  bit idle_on = 1'b1;           // random idling on both sides
  int items_sent, results_seen, mismatches, configs_written, trips, snoozes;
  int sink_stall, quiet_cycles;

  task automatic clear_alarm_model();
    set_hour       = 5'd8;
    set_minute     = 6'd0;
    set_alarm_len  = 15'd300;
    set_snooze_len = 15'd540;
    set_tone_len   = 16'd150;
    armed_q        = 1'b0;
    alarming_q     = 1'b0;
    snoozing_q     = 1'b0;
    stop_req_q     = 1'b0;
    silence_req_q  = 1'b0;
    piezo_q        = 1'b0;
    next_tone_q    = 1'b0;
    alarm_left_q   = '0;
    snooze_left_q  = '0;
    slot_left_q    = '0;
    seen_second_q  = LAST_SECOND_RESET;
  endtask

  // advance the alarm state by one item and return the result it produces
  function automatic acc_result_t step_alarm(input alarm_item_t it);
    acc_result_t r;
    r = '0;
    case (it.kind)
      KIND_POLL: begin
        // a stop request empties the alarm countdown at the next poll
        if (stop_req_q) begin
          alarm_left_q = '0;
          stop_req_q   = 1'b0;
        end
        // alarm switch level
        if (it.switch_off) begin
          if (armed_q) begin
            armed_q       = 1'b0;
            snooze_left_q = '0;
            alarm_left_q  = '0;
            if (alarming_q) begin
              alarming_q  = 1'b0;
              snoozing_q  = 1'b0;
              piezo_q     = 1'b0;
              next_tone_q = 1'b0;
            end
          end
        end else if (!armed_q) begin
          armed_q       = 1'b1;
          snooze_left_q = '0;
          alarm_left_q  = '0;
          next_tone_q   = 1'b0;
        end
        // countdowns only move on a newly seen second, any 6-bit value counts
        if (it.second != seen_second_q) begin
          if (alarming_q) begin
            if (snooze_left_q == 15'd1) begin
              r.snooze_event = 1'b1;
              snoozing_q     = 1'b0;
              next_tone_q    = 1'b0;
            end
            if (snooze_left_q != '0) snooze_left_q = snooze_left_q - 15'd1;
            if (alarm_left_q != '0) alarm_left_q = alarm_left_q - 16'd1;
          end
          seen_second_q = it.second;
          r.time_event  = 1'b1;
        end
        if (armed_q) begin
          if (!alarming_q && it.second == 6'd0 && it.minute == set_minute &&
              it.hour == set_hour) begin
            alarming_q    = 1'b1;
            r.alarm_event = 1'b1;
            alarm_left_q  = 16'(set_alarm_len);
            trips++;
          end else if (alarming_q && alarm_left_q == '0) begin
            alarming_q    = 1'b0;
            snoozing_q    = 1'b0;
            r.alarm_event = 1'b1;
            snooze_left_q = '0;
            silence_req_q = 1'b1;
          end
        end
      end
      KIND_STOP: begin
        if (alarming_q) stop_req_q = 1'b1;
      end
      KIND_SNOOZE: begin
        if (alarming_q) begin
          snooze_left_q  = set_snooze_len;
          r.snooze_event = 1'b1;
          snoozing_q     = 1'b1;
          // the sum of two 15-bit lengths always fits 16 bits
          alarm_left_q   = 16'(set_alarm_len) + 16'(set_snooze_len);
          piezo_q        = 1'b0;
          snoozes++;
        end
      end
      default: begin
        // millisecond tick: tone and silence slots while audible
        if (alarming_q && snooze_left_q == '0) begin
          if (slot_left_q == '0) begin
            slot_left_q = set_tone_len;
            if (!piezo_q) begin
              piezo_q     = 1'b1;
              next_tone_q = ~next_tone_q;
            end else begin
              piezo_q = 1'b0;
            end
          end
          // a zero period wraps here, giving a 65536-tick slot
          slot_left_q = slot_left_q - 16'd1;
        end else if (silence_req_q) begin
          piezo_q       = 1'b0;
          silence_req_q = 1'b0;
          next_tone_q   = 1'b0;
        end
      end
    endcase
    r.sound_on            = piezo_q;
    r.tone_select         = piezo_q & ~next_tone_q;
    r.alarming            = alarming_q;
    r.snoozing            = snoozing_q;
    r.armed               = armed_q;
    r.snooze_seconds_left = snooze_left_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // item builders
  // ---------------------------------------------------------------------------
  function automatic alarm_item_t poll_at(input int hh, input int mm, input int ss,
                                          input bit off);
    alarm_item_t it;
    it.kind       = KIND_POLL;
    it.hour       = 5'(hh);
    it.minute     = 6'(mm);
    it.second     = 6'(ss);
    it.switch_off = off;
    return it;
  endfunction

  // non-poll kinds carry junk in the time fields, which must be ignored
  function automatic alarm_item_t button(input kind_t k);
    alarm_item_t it;
    it.kind       = k;
    it.hour       = 5'($urandom_range(0, 31));
    it.minute     = 6'($urandom_range(0, 63));
    it.second     = 6'($urandom_range(0, 63));
    it.switch_off = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic alarm_item_t random_item();
    kind_t k;
    k = kind_t'($urandom_range(0, 3));
    if (k == KIND_POLL)
      return poll_at($urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                     1'($urandom_range(0, 1)));
    return button(k);
  endfunction

  // ---------------------------------------------------------------------------
  // slave side driver and configuration writes
  // ---------------------------------------------------------------------------

  // one transfer on the slave side; valid stays high afterwards so that
  // back-to-back items go out without a bubble
  task automatic send_item(input alarm_item_t it);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, it.switch_off, it.second, it.minute, it.hour};
    s_tuser  <= it.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(step_alarm(it));
    items_sent++;
  endtask

  // drop valid and hold off until every expected result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // write all five registers, only while nothing is in flight
  task automatic set_config(input int unsigned hr, mn, alen, slen, tone);
    logic [CFG_INDEX_W-1:0] regs [5];
    logic [CFG_DATA_W-1:0]  vals [5];
    regs = '{REG_ALARM_HOUR, REG_ALARM_MINUTE, REG_ALARM_DUR, REG_SNOOZE_DUR,
             REG_TONE_PERIOD};
    vals = '{16'(hr), 16'(mn), 16'(alen), 16'(slen), 16'(tone)};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we         <= 1'b0;
    set_hour       = 5'(hr);
    set_minute     = 6'(mn);
    set_alarm_len  = 15'(alen);
    set_snooze_len = 15'(slen);
    set_tone_len   = 16'(tone);
    configs_written++;
  endtask

  // ---------------------------------------------------------------------------
  // master side: random back-pressure and result checking
  // ---------------------------------------------------------------------------
  function automatic string describe(input acc_result_t r);
    return $sformatf("snd=%0b tone=%0b alm=%0b snz=%0b arm=%0b tev=%0b aev=%0b sev=%0b left=%0d",
                     r.sound_on, r.tone_select, r.alarming, r.snoozing, r.armed,
                     r.time_event, r.alarm_event, r.snooze_event, r.snooze_seconds_left);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_result(input acc_result_t got);
    acc_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch({"result with nothing expected: ", describe(got)});
      return;
    end
    want = expected_results.pop_front();
    results_seen++;
    if (got.sound_on !== want.sound_on || got.tone_select !== want.tone_select ||
        got.alarming !== want.alarming || got.snoozing !== want.snoozing ||
        got.armed !== want.armed || got.time_event !== want.time_event ||
        got.alarm_event !== want.alarm_event || got.snooze_event !== want.snooze_event ||
        got.snooze_seconds_left !== want.snooze_seconds_left)
      report_mismatch({"result ", $sformatf("%0d", results_seen), " exp ", describe(want),
                       " got ", describe(got)});
  endtask

  // a transfer is sampled with the values from before the edge; tready is
  // then set for the next cycle, with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) check_result(acc_result_t'(m_tdata[22:0]));
      if (sink_stall != 0) begin
        m_tready   <= 1'b0;
        sink_stall <= sink_stall - 1;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        m_tready   <= 1'b0;
        sink_stall <= $urandom_range(0, 17);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_results.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset defaults, ignored requests, out-of-range seconds, switch handling
  task automatic test_idle_inputs();
    send_item(poll_at(0, 0, 0, 1'b1));      // first poll after reset is a new second
    send_item(poll_at(0, 0, 0, 1'b1));      // same second, no time event
    send_item(button(KIND_STOP));           // requests while not alarming do nothing
    send_item(button(KIND_SNOOZE));
    send_item(button(KIND_TICK));
    send_item(poll_at(23, 59, 59, 1'b0));   // switch on arms
    send_item(poll_at(31, 63, 63, 1'b0));   // out-of-range time fields
    send_item(poll_at(31, 63, 63, 1'b1));   // switch off disarms
    send_item(poll_at(8, 0, 0, 1'b0));      // re-arm and trip at the default 08:00:00
    repeat (3) send_item(button(KIND_TICK));
    send_item(poll_at(8, 0, 0, 1'b1));      // switch off while audible kills the alarm
    send_item(button(KIND_TICK));
    wait_drained();
  endtask

  // one full alarm: two-tone play, snooze and its timeout, stop, pending silence
  task automatic test_alarm_cycle();
    set_config(23, 59, 3, 2, 2);
    send_item(poll_at(23, 58, 59, 1'b0));
    send_item(poll_at(23, 59, 0, 1'b0));    // trip
    repeat (5) send_item(button(KIND_TICK));
    send_item(button(KIND_SNOOZE));
    send_item(button(KIND_TICK));           // silent while snoozing
    send_item(poll_at(23, 59, 1, 1'b0));
    send_item(poll_at(23, 59, 2, 1'b0));    // snooze runs out
    repeat (2) send_item(button(KIND_TICK));
    send_item(button(KIND_STOP));
    send_item(button(KIND_TICK));
    send_item(poll_at(23, 59, 3, 1'b0));    // stop takes effect, alarm over
    send_item(poll_at(23, 59, 4, 1'b1));    // switching off keeps the silence pending
    send_item(button(KIND_STOP));
    send_item(button(KIND_TICK));           // piezo goes quiet here
    wait_drained();
  endtask

  // zero alarm length, zero snooze length and zero tone period
  task automatic test_zero_lengths();
    set_config(0, 0, 0, 0, 0);
    send_item(poll_at(0, 0, 59, 1'b0));
    send_item(poll_at(0, 0, 0, 1'b0));      // trip with nothing on the countdown
    send_item(poll_at(0, 0, 1, 1'b0));      // ends on the next poll
    send_item(button(KIND_TICK));
    send_item(poll_at(0, 0, 0, 1'b0));      // trip again
    send_item(button(KIND_SNOOZE));         // zero snooze: snoozing but still audible
    repeat (3) send_item(button(KIND_TICK));
    send_item(poll_at(0, 0, 0, 1'b0));
    wait_drained();
  endtask

  function automatic int unsigned pick_len(input int unsigned longest);
    case ($urandom_range(0, 19))
      0, 1:    return 0;
      2:       return 32767;
      default: return $urandom_range(1, longest);
    endcase
  endfunction

  function automatic int unsigned pick_tone();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 65535;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  // a clock running up to the alarm time and through the alarm, with ticks,
  // snoozes, stops, switch flips and stray items mixed in
  task automatic run_alarm_scenario();
    int hh, mm, ss, polls, cap;
    bit tripped;
    hh = set_hour;
    mm = set_minute;
    ss = 60 - $urandom_range(1, 3);
    if (mm == 0) begin
      mm = 59;
      hh = (hh == 0) ? 23 : hh - 1;
    end else begin
      mm = mm - 1;
    end
    cap     = 12 + $urandom_range(0, 28);
    polls   = 0;
    tripped = 1'b0;
    while (polls < cap && !(tripped && !alarming_q)) begin
      send_item(poll_at(hh, mm, ss, $urandom_range(0, 39) == 0));
      if (alarming_q) tripped = 1'b1;
      polls++;
      // sometimes a second poll lands within the same second
      if ($urandom_range(0, 5) == 0) send_item(poll_at(hh, mm, ss, 1'b0));
      repeat ($urandom_range(0, 4)) send_item(button(KIND_TICK));
      case ($urandom_range(0, 39))
        0, 1: send_item(button(KIND_SNOOZE));
        2:    send_item(button(KIND_STOP));
        3, 4: send_item(random_item());
        5:    wait_drained();
        default: ;
      endcase
      ss++;
      if (ss == 60) begin
        ss = 0;
        mm++;
        if (mm == 60) begin
          mm = 0;
          hh = (hh + 1) % 24;
        end
      end
    end
    // long alarms are cut short by a stop
    if (alarming_q) begin
      send_item(button(KIND_STOP));
      send_item(poll_at(hh, mm, (ss + 1) % 60, 1'b0));
    end
    repeat ($urandom_range(1, 3)) send_item(button(KIND_TICK));
  endtask

  task automatic test_random_alarms();
    int phase;
    phase = 0;
    while (items_sent < ITEM_TARGET - TAIL_ITEMS) begin
      case (phase)
        0:       set_config(0, 0, 1, 1, 1);
        1:       set_config(23, 59, 32767, 32767, 65535);
        default: set_config($urandom_range(0, 23), $urandom_range(0, 59), pick_len(12),
                            pick_len(8), pick_tone());
      endcase
      repeat ($urandom_range(3, 6)) run_alarm_scenario();
      wait_drained();
      phase++;
    end
  endtask

  // last stretch at full rate on both sides
  task automatic test_full_rate_tail();
    idle_on = 1'b0;
    set_config($urandom_range(0, 23), $urandom_range(0, 59), pick_len(10), pick_len(6),
               $urandom_range(1, 4));
    while (items_sent < ITEM_TARGET) run_alarm_scenario();
    wait_drained();
  endtask

  initial begin
    clear_alarm_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_inputs();
    test_alarm_cycle();
    test_zero_lengths();
    test_random_alarms();
    test_full_rate_tail();
    // let any stray result surface before the verdict
    repeat (6) @(posedge clk);
    $display("ran %0d items, checked %0d results across %0d register settings",
             items_sent, results_seen, configs_written);
    $display("alarm trips %0d, snoozes taken %0d, mismatches %0d",
             trips, snoozes, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
